[hdl/plsq_pkg.sv]
package plsq_pkg;

  // default capacity of one calibration set
  localparam int unsigned MAX_POINTS_DEF = 256;

  // register reset value, Q4.8
  localparam logic [11:0] DEFAULT_DAMP_RST = 12'd512;

  // log10(2) in Q.16, applied to a Q.16 log2 value and scaled by 2^-20
  localparam int LOG10_OF_2_Q16 = 19728;

  // clamp limits and replacement values
  localparam int DAMP_HIGH     = 1280;
  localparam int DAMP_HIGH_SET = 1152;
  localparam int DAMP_LOW      = 256;
  localparam int DAMP_LOW_SET  = 384;
  localparam int TX_LOW        = -1440;
  localparam int TX_LOW_SET    = -1200;
  localparam int TX_HIGH       = -640;
  localparam int TX_HIGH_SET   = -1008;

  typedef struct packed {
    logic [15:0]        distance;
    logic signed [11:0] rssi;
    logic               has_point;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] tx_power;
    logic [10:0]        damp_value;
    logic               fit_ok;
    logic [8:0]         points_used;
  } out_item_t;

  typedef enum logic [0:0] {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

[hdl/plsq_alu.sv]
module plsq_alu #(
  parameter int unsigned W = 73
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plsq_pkg::alu_req_t  req_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic                done_o,
  output logic signed [W-1:0] res_o
);
  import plsq_pkg::*;

  localparam int unsigned CNT_W = $clog2(W + 1);

  alu_op_e             op_q;
  logic                busy_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic signed [W-1:0] x_q;    // multiplicand, or dividend / quotient shifter
  logic signed [W-1:0] y_q;    // multiplier, or divisor
  logic signed [W-1:0] acc_q;  // product, or partial remainder

  logic [W:0] trial;
  logic [W:0] trial_sub;
  logic       trial_ge;

  // restoring division step
  assign trial     = {acc_q, x_q[W-1]};
  assign trial_ge  = trial >= {1'b0, y_q};
  assign trial_sub = trial - {1'b0, y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= ALU_MUL;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        op_q   <= req_i.op;
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(W);
        acc_q  <= '0;
        if (req_i.op == ALU_MUL && b_i[W-1]) begin
          x_q <= -a_i;
          y_q <= -b_i;
        end else begin
          x_q <= a_i;
          y_q <= b_i;
        end
      end else if (busy_q) begin
        unique case (op_q)
          ALU_MUL: begin
            if (y_q == '0) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end else begin
              if (y_q[0]) begin
                acc_q <= acc_q + x_q;
              end
              x_q <= x_q <<< 1;
              y_q <= y_q >>> 1;
            end
          end
          ALU_DIV: begin
            if (trial_ge) begin
              acc_q <= signed'(trial_sub[W-1:0]);
            end else begin
              acc_q <= signed'(trial[W-1:0]);
            end
            x_q   <= {x_q[W-2:0], trial_ge};
            cnt_q <= cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          default: busy_q <= 1'b0;
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == ALU_MUL) ? acc_q : x_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_q)
    else $error("alu done while still busy");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("alu started while busy");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && op_q == ALU_DIV) |-> ({1'b0, acc_q} < {1'b0, y_q}))
    else $error("partial remainder not below divisor");

endmodule

[hdl/path_loss_least_squares_fit.sv]
// path loss least squares fit
// fits rssi = t - 10*n*log10(d) over a set of calibration points
// input channel (in_valid_i / in_ready_o / in_data_i): one item per point or
//   set marker; has_point adds the point, last closes the set and fits
// output channel (out_valid_o / out_ready_i / out_data_o): one item per set,
//   with fitted tx power, path loss exponent, fit_ok and the point count
// cfg_we_i / cfg_wdata_i write the exponent used for a one-point set
// a point item forms its log10 by 16 squarings on the shared 21x17
//   multiplier, then scales it and runs the two product accumulations
// an item closing the set adds the fit: one point uses the shared multiplier
//   and the configured exponent; two or more run up to six products through
//   the serial shift-add unit and up to two restoring divisions
// in_ready_o is high only while no item is in work
// a finished result sits in the output register; the next set is taken
//   meanwhile, and only its own result waits for that register to drain
// reset clears the sums and the count, drops any pending result and sets
//   the one-point exponent to 2.0
module path_loss_least_squares_fit #(
  parameter int unsigned MAX_POINTS = plsq_pkg::MAX_POINTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  plsq_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output plsq_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [11:0]         cfg_wdata_i
);
  import plsq_pkg::*;

  // count and running sum widths follow the set size
  localparam int unsigned CW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned SX_W  = 15 + CW;
  localparam int unsigned SY_W  = 11 + CW;
  localparam int unsigned SXX_W = 31 + CW;
  localparam int unsigned SXY_W = 35 + CW;
  // fit arithmetic width: holds every product and the scaled divide operand
  localparam int unsigned AW    = SXX_W + CW + 24;
  // shared per-point multiplier
  localparam int unsigned MA_W  = 21;
  localparam int unsigned MB_W  = 17;
  localparam int unsigned PW    = MA_W + MB_W;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ_MUL,
    S_SQ_UPD,
    S_X_MUL,
    S_X_RND,
    S_XX_MUL,
    S_XY_MUL,
    S_XY_ACC,
    S_FIT,
    S_ONE_MUL,
    S_ONE_RND,
    S_PGO,
    S_PWAIT,
    S_TPREP,
    S_TGO,
    S_TWAIT,
    S_NPREP,
    S_NCHK,
    S_NGO,
    S_NWAIT,
    S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [11:0] dflt_q;

  // set state
  logic [CW-1:0]           cnt_q;
  logic                    bad_q;
  logic signed [SX_W-1:0]  sx_q;
  logic signed [SY_W-1:0]  sy_q;
  logic signed [SXX_W-1:0] sxx_q;
  logic signed [SXY_W-1:0] sxy_q;

  // current point
  logic               last_q;
  logic signed [11:0] rssi_q;
  logic [3:0]         lead_q;
  logic [15:0]        mant_q;
  logic [15:0]        frac_q;
  logic [3:0]         it_q;
  logic signed [14:0] x_q;

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [PW-1:0]   prod_q;

  // fit
  logic [2:0]           k_q;
  logic signed [AW-1:0] t1_q;
  logic signed [AW-1:0] den_q;
  logic signed [AW-1:0] neg_q;
  logic signed [AW-1:0] nt_q;
  logic                 sneg_q;
  logic signed [AW-1:0] tx_q;
  logic [16:0]          damp_q;
  logic                 ok_q;

  // output register
  logic      out_valid_q;
  out_item_t out_data_q;

  // serial unit
  alu_req_t             alu_req;
  logic signed [AW-1:0] alu_a;
  logic signed [AW-1:0] alu_b;
  logic                 alu_done;
  logic signed [AW-1:0] alu_res;

  logic signed [AW-1:0] pdiff;
  logic [3:0]           lead_d;
  logic [16:0]          sq;
  logic signed [PW-1:0] x_sum;
  logic signed [14:0]   x_new;
  logic signed [PW-1:0] one_sum;
  logic signed [PW-17:0] one_rnd;
  logic signed [AW-1:0] n_ext;
  logic [16:0]          ten_damp;
  logic signed [11:0]   tx_c;
  logic [10:0]          damp_c;

  // leading one of the distance, integer part of log2 is lead - 8
  always_comb begin
    lead_d = '0;
    for (int i = 0; i < 16; i++) begin
      if (in_data_i.distance[i]) begin
        lead_d = 4'(i);
      end
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // squared mantissa in Q2.15, top bit is the next fraction bit
  assign sq       = prod_q[31:15];
  // log10 = round(log2 * log10(2)), Q3.12
  assign x_sum    = prod_q + PW'(524288);
  assign x_new    = x_sum[34:20];
  // one-point fit: round(10 * n * x / 2^16)
  assign one_sum  = prod_q + PW'(32768);
  assign one_rnd  = one_sum[PW-1:16];
  assign ten_damp = {2'b00, dflt_q, 3'b000} + {4'b0000, dflt_q, 1'b0};
  assign n_ext    = AW'(signed'({1'b0, cnt_q}));
  assign pdiff    = t1_q - alu_res;

  // multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ_MUL: begin
        mul_a = MA_W'(signed'({1'b0, mant_q}));
        mul_b = MB_W'(signed'({1'b0, mant_q}));
      end
      S_X_MUL: begin
        // log2 in Q.16: integer part lead - 8 as 4-bit two's complement
        mul_a = MA_W'(signed'({~lead_q[3], lead_q[2:0], frac_q}));
        mul_b = MB_W'(LOG10_OF_2_Q16);
      end
      S_XX_MUL: begin
        mul_a = MA_W'(x_q);
        mul_b = MB_W'(x_q);
      end
      S_XY_MUL: begin
        mul_a = MA_W'(x_q);
        mul_b = MB_W'(rssi_q);
      end
      S_ONE_MUL: begin
        mul_a = MA_W'(sx_q);
        mul_b = signed'(ten_damp);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // serial unit requests and operands
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_a         = '0;
    alu_b         = '0;
    case (state_q)
      S_PGO: begin
        alu_req.start = 1'b1;
        case (k_q)
          3'd0: begin alu_a = AW'(sxx_q); alu_b = n_ext;       end
          3'd1: begin alu_a = AW'(sx_q);  alu_b = AW'(sx_q);  end
          3'd2: begin alu_a = AW'(sxy_q); alu_b = n_ext;       end
          3'd3: begin alu_a = AW'(sx_q);  alu_b = AW'(sy_q);  end
          3'd4: begin alu_a = AW'(sxx_q); alu_b = AW'(sy_q);  end
          default: begin alu_a = AW'(sxy_q); alu_b = AW'(sx_q); end
        endcase
      end
      S_TGO: begin
        // floor division of a negative value: ~(|s| - 1) / d, i.e. ~(~s / d)
        alu_req.start = 1'b1;
        alu_req.op    = ALU_DIV;
        alu_a         = nt_q[AW-1] ? ~nt_q : nt_q;
        alu_b         = den_q <<< 1;
      end
      S_NGO: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_DIV;
        alu_a         = neg_q <<< 17;
        alu_b         = t1_q;
      end
      default: begin
        alu_req.start = 1'b0;
      end
    endcase
  end

  plsq_alu #(
    .W (AW)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  // result clamps, zero for an invalid fit
  always_comb begin
    if (!ok_q) begin
      tx_c   = '0;
      damp_c = '0;
    end else begin
      if (tx_q < TX_LOW) begin
        tx_c = 12'(TX_LOW_SET);
      end else if (tx_q > TX_HIGH) begin
        tx_c = 12'(TX_HIGH_SET);
      end else begin
        tx_c = tx_q[11:0];
      end
      if (damp_q > DAMP_HIGH) begin
        damp_c = 11'(DAMP_HIGH_SET);
      end else if (damp_q < DAMP_LOW) begin
        damp_c = 11'(DAMP_LOW_SET);
      end else begin
        damp_c = damp_q[10:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dflt_q      <= DEFAULT_DAMP_RST;
      cnt_q       <= '0;
      bad_q       <= 1'b0;
      sx_q        <= '0;
      sy_q        <= '0;
      sxx_q       <= '0;
      sxy_q       <= '0;
      last_q      <= 1'b0;
      rssi_q      <= '0;
      lead_q      <= '0;
      mant_q      <= '0;
      frac_q      <= '0;
      it_q        <= '0;
      x_q         <= '0;
      prod_q      <= '0;
      k_q         <= '0;
      t1_q        <= '0;
      den_q       <= '0;
      neg_q       <= '0;
      nt_q        <= '0;
      sneg_q      <= 1'b0;
      tx_q        <= '0;
      damp_q      <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      prod_q <= PW'(mul_a) * PW'(mul_b);
      if (cfg_we_i) begin
        dflt_q <= cfg_wdata_i;
      end
      // in S_OUT the output register is reloaded or kept below
      if (out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            last_q <= in_data_i.last;
            rssi_q <= in_data_i.rssi;
            lead_q <= lead_d;
            mant_q <= in_data_i.distance << (4'd15 - lead_d);
            it_q   <= '0;
            if (in_data_i.has_point && cnt_q >= CW'(MAX_POINTS)) begin
              // set full: point dropped
              bad_q <= 1'b1;
              state_q <= in_data_i.last ? S_FIT : S_IDLE;
            end else if (in_data_i.has_point && in_data_i.distance == '0) begin
              bad_q   <= 1'b1;
              cnt_q   <= cnt_q + CW'(1);
              state_q <= in_data_i.last ? S_FIT : S_IDLE;
            end else if (in_data_i.has_point) begin
              state_q <= S_SQ_MUL;
            end else begin
              state_q <= in_data_i.last ? S_FIT : S_IDLE;
            end
          end
        end
        S_SQ_MUL: state_q <= S_SQ_UPD;
        S_SQ_UPD: begin
          frac_q <= {frac_q[14:0], sq[16]};
          mant_q <= sq[16] ? sq[16:1] : sq[15:0];
          it_q   <= it_q + 4'd1;
          state_q <= (it_q == 4'd15) ? S_X_MUL : S_SQ_MUL;
        end
        S_X_MUL: state_q <= S_X_RND;
        S_X_RND: begin
          x_q     <= x_new;
          state_q <= S_XX_MUL;
        end
        S_XX_MUL: state_q <= S_XY_MUL;
        S_XY_MUL: begin
          sxx_q   <= sxx_q + SXX_W'(prod_q);
          state_q <= S_XY_ACC;
        end
        S_XY_ACC: begin
          sxy_q   <= sxy_q + SXY_W'(prod_q);
          sx_q    <= sx_q + SX_W'(x_q);
          sy_q    <= sy_q + SY_W'(rssi_q);
          cnt_q   <= cnt_q + CW'(1);
          state_q <= last_q ? S_FIT : S_IDLE;
        end
        S_FIT: begin
          k_q <= '0;
          if (bad_q || cnt_q == '0) begin
            ok_q    <= 1'b0;
            state_q <= S_OUT;
          end else if (cnt_q == CW'(1)) begin
            ok_q    <= 1'b1;
            state_q <= S_ONE_MUL;
          end else begin
            ok_q    <= 1'b1;
            state_q <= S_PGO;
          end
        end
        S_ONE_MUL: state_q <= S_ONE_RND;
        S_ONE_RND: begin
          tx_q    <= AW'(sy_q) + AW'(one_rnd);
          damp_q  <= 17'(dflt_q);
          state_q <= S_OUT;
        end
        S_PGO: state_q <= S_PWAIT;
        S_PWAIT: begin
          if (alu_done) begin
            k_q     <= k_q + 3'd1;
            state_q <= S_PGO;
            case (k_q)
              3'd1: begin
                // den = n*sxx - sx^2
                den_q <= pdiff;
                if (pdiff <= 0) begin
                  ok_q    <= 1'b0;
                  state_q <= S_OUT;
                end
              end
              3'd3: neg_q <= alu_res - t1_q;  // -(n*sxy - sx*sy)
              3'd5: begin
                nt_q    <= pdiff;              // sy*sxx - sx*sxy
                state_q <= S_TPREP;
              end
              default: t1_q <= alu_res;
            endcase
          end
        end
        S_TPREP: begin
          // round half up: floor((2*nt + den) / (2*den))
          nt_q    <= (nt_q <<< 1) + den_q;
          state_q <= S_TGO;
        end
        S_TGO: begin
          sneg_q  <= nt_q[AW-1];
          state_q <= S_TWAIT;
        end
        S_TWAIT: begin
          if (alu_done) begin
            tx_q    <= sneg_q ? ~alu_res : alu_res;
            state_q <= S_NPREP;
          end
        end
        S_NPREP: begin
          if (neg_q <= 0) begin
            // zero or rising slope, clamps to the low setting
            damp_q  <= '0;
            state_q <= S_OUT;
          end else begin
            t1_q    <= (den_q <<< 3) + (den_q <<< 1);
            state_q <= S_NCHK;
          end
        end
        S_NCHK: begin
          if (neg_q >= t1_q) begin
            // exponent of 256 or more, saturate
            damp_q  <= 17'h10000;
            state_q <= S_OUT;
          end else begin
            state_q <= S_NGO;
          end
        end
        S_NGO: state_q <= S_NWAIT;
        S_NWAIT: begin
          if (alu_done) begin
            damp_q  <= 17'((18'(alu_res[16:0]) + 18'd1) >> 1);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q            <= 1'b1;
            out_data_q.tx_power    <= tx_c;
            out_data_q.damp_value  <= damp_c;
            out_data_q.fit_ok      <= ok_q;
            out_data_q.points_used <= 9'(cnt_q);
            cnt_q   <= '0;
            bad_q   <= 1'b0;
            sx_q    <= '0;
            sy_q    <= '0;
            sxx_q   <= '0;
            sxy_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_POINTS))
    else $error("point count beyond set capacity");

  a_ok_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.fit_ok) |->
      (out_data_o.damp_value >= 11'(DAMP_LOW) && out_data_o.damp_value <= 11'(DAMP_HIGH)
       && out_data_o.tx_power >= 12'(TX_LOW) && out_data_o.tx_power <= 12'(TX_HIGH)))
    else $error("valid fit outside clamp range");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.fit_ok) |->
      (out_data_o.tx_power == '0 && out_data_o.damp_value == '0))
    else $error("invalid fit with nonzero values");

  a_bad_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(bad_q) |-> $past(state_q == S_OUT))
    else $error("bad set flag cleared before the result");

endmodule
